// ----- hw/rtl/smt_pkg.sv -----
// shared widths, defaults and action codes for the set membership table
package smt_pkg;

    localparam int ACTION_W      = 2;
    localparam int ELEMENT_W     = 16;
    localparam int COUNT_W       = 7;

    localparam int CAPACITY_DEF  = 64;
    localparam int ELEM_BITS_DEF = 16;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;

endpackage

// ----- hw/rtl/smt_if.sv -----
// request and result channel interfaces of the set membership table
interface smt_in_if;
    logic                          valid;
    logic                          ready;
    logic [smt_pkg::ACTION_W-1:0]  action;
    logic [smt_pkg::ELEMENT_W-1:0] element;

    modport source (output valid, output action, output element, input ready);
    modport sink   (input valid, input action, input element, output ready);
endinterface

interface smt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        was_present;
    logic                        rejected;
    logic [smt_pkg::COUNT_W-1:0] entry_count;
    logic                        is_empty;
    logic                        is_full;

    modport source (output valid, output was_present, output rejected,
                    output entry_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input was_present, input rejected,
                    input entry_count, input is_empty, input is_full, output ready);
endinterface

// ----- hw/rtl/set_membership_table.sv -----
// set membership table: packed ordered set of distinct values in one ram
//
// i_in carries one request per transfer: action (insert, delete, anything
// else is a query) and element. o_out returns one result per request:
// was_present, rejected, entry_count, is_empty and is_full after the request.
// Requests are handled one at a time. The store is a synchronous ram with a
// registered read; the lookup streams one entry per cycle through its read
// port, from the first entry until a match or the end of the set. A delete
// of a present value then moves every later entry down one place, reading
// one entry and writing the one before it each cycle.
// The result sits in an output register, so a new request is taken while the
// previous result still waits; if the receiver stalls, the next result is
// held back until that register empties and the block waits there.
// Reset empties the set at once (count to zero); ram contents are not
// cleared, since only entries below the count are ever read.
module set_membership_table #(
    parameter int CAPACITY  = smt_pkg::CAPACITY_DEF,
    parameter int ELEM_BITS = smt_pkg::ELEM_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smt_in_if.sink     i_in,
    smt_out_if.source  o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_rd_idx, n_rd_idx;
    logic                          r_pend, n_pend;
    logic [AW-1:0]                 r_pend_idx, n_pend_idx;
    logic [smt_pkg::ACTION_W-1:0]  r_action, n_action;
    logic [ELEM_BITS-1:0]          r_value, n_value;
    logic                          r_present, n_present;
    logic                          r_reject, n_reject;
    logic                          r_out_valid, n_out_valid;
    logic                          r_o_present, n_o_present;
    logic                          r_o_reject, n_o_reject;
    logic [CW-1:0]                 r_o_count, n_o_count;

    logic [ELEM_BITS-1:0]          r_mem [CAPACITY];
    logic [ELEM_BITS-1:0]          r_mem_q;
    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;
    logic [ELEM_BITS-1:0]          mem_wdata;

    logic                          hit, rd_more, scan_end;

    // element store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    assign hit      = r_pend && (r_mem_q == r_value);
    assign rd_more  = r_rd_idx < r_count;
    assign scan_end = hit || (!r_pend && !rd_more);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_action    = r_action;
        n_value     = r_value;
        n_present   = r_present;
        n_reject    = r_reject;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_present = r_o_present;
        n_o_reject  = r_o_reject;
        n_o_count   = r_o_count;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_count[AW-1:0];
        mem_raddr   = r_rd_idx[AW-1:0];
        mem_wdata   = r_value;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_action = i_in.action;
                    n_value  = ELEM_BITS'(i_in.element);
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_present = hit;
                    n_reject  = 1'b0;
                    n_pend    = 1'b0;
                    if (r_action == smt_pkg::ACT_INSERT && !hit) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_reject = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                        n_state = S_DONE;
                    end else if (r_action == smt_pkg::ACT_DELETE && hit) begin
                        // close the gap starting just after the matching slot
                        n_rd_idx = CW'(r_pend_idx) + 1'b1;
                        n_state  = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (rd_more) begin
                    mem_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[AW-1:0];
                    n_rd_idx   = r_rd_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_SHIFT: begin
                // entry read last cycle lands one place lower
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pend_idx - 1'b1;
                    mem_wdata = r_mem_q;
                end
                if (rd_more) begin
                    mem_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[AW-1:0];
                    n_rd_idx   = r_rd_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_present = r_present;
                    n_o_reject  = r_reject;
                    n_o_count   = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx  <= n_pend_idx;
        r_action    <= n_action;
        r_value     <= n_value;
        r_present   <= n_present;
        r_reject    <= n_reject;
        r_o_present <= n_o_present;
        r_o_reject  <= n_o_reject;
        r_o_count   <= n_o_count;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.was_present = r_o_present;
    assign o_out.rejected    = r_o_reject;
    assign o_out.entry_count = smt_pkg::COUNT_W'(r_o_count);
    assign o_out.is_empty    = (r_o_count == '0);
    assign o_out.is_full     = (r_o_count == CW'(CAPACITY));

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_count_moves_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == S_SCAN || $past(r_state) == S_SHIFT))
        else $error("element count changed outside scan or shift");

    a_no_read_left_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("ram read outstanding while idle");

    a_reject_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rejected) |-> (o_out.is_full && !o_out.was_present))
        else $error("insert rejected while set not full");

endmodule
